// ===== rtl/core/cdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdd_pkg
// Types, constants and fixed-point helpers for the cardiac cell derivative core.
// ----------------------------------------------------------------------------
package cdd_pkg;

  typedef struct packed {
    logic signed [31:0] v;
    logic signed [31:0] r;
    logic signed [31:0] ta;
    logic signed [31:0] aux;
    logic signed [31:0] stim;
  } cdd_in_t;

  typedef struct packed {
    logic signed [31:0] dv;
    logic signed [31:0] dr;
    logic signed [31:0] dta;
    logic signed [31:0] daux;
  } cdd_out_t;

  // Values carried alongside the dividers.
  typedef struct packed {
    logic signed [31:0] dv;
    logic signed [31:0] g;
    logic signed [31:0] kt;
    logic signed [31:0] daux;
    logic               rz;
    logic               vlo;
  } cdd_side_t;

  localparam int QuoW   = 48;          // quotient bits of (n << 16) / d
  localparam int DivLat = QuoW + 2;    // prep stage, one stage per bit, output stage

  localparam logic signed [63:0] FxOne   = 64'sd65536;
  localparam logic signed [63:0] FxA     = 64'sd4915;
  localparam logic signed [63:0] FxEps   = 64'sd131;
  localparam logic signed [31:0] FxMu1   = 32'sd13107;
  localparam logic signed [63:0] FxMu2   = 64'sd19661;
  localparam logic signed [63:0] FxKta   = 64'sd50;
  localparam logic signed [31:0] FxErr   = 32'sd328;
  localparam logic signed [31:0] FxVth   = 32'sd3277;
  localparam logic signed [31:0] FxAuxth = 32'sd6554;
  localparam logic signed [31:0] FxVmin  = 32'sd655;
  localparam logic signed [31:0] FxC006  = 32'sd3932;
  localparam logic signed [31:0] FxC001  = 32'sd655;
  localparam logic signed [31:0] FxDecay = 32'sd6554;
  localparam logic signed [31:0] FxMax   = 32'sh7fffffff;
  localparam logic signed [31:0] FxMin   = 32'sh80000000;
  localparam logic [31:0]        Recip3  = 32'haaaaaaab;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x > 64'sd2147483647) begin
      res = FxMax;
    end else if (x < -64'sd2147483648) begin
      res = FxMin;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

  // Rounded Q16.16 product, ties toward plus infinity, saturated.
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd32768;
    return sat32(p >>> 16);
  endfunction

endpackage

// ===== rtl/core/cdd_delay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdd_delay
// Fixed-length register delay line that keeps side values aligned with the dividers.
// ----------------------------------------------------------------------------
module cdd_delay #(
  parameter int Width = 8,
  parameter int Depth = 1
) (
  input  logic             clk,
  input  logic [Width-1:0] din,
  output logic [Width-1:0] dout
);
  logic [Width-1:0] tap_r [Depth];

  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int i = 1; i < Depth; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[Depth-1];
endmodule

// ===== rtl/core/cdd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdd_div
// Pipelined Q16.16 divider: one restoring quotient bit per stage, saturated result.
// ----------------------------------------------------------------------------
module cdd_div (
  input  logic               clk,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic signed [31:0] quo
);
  import cdd_pkg::*;

  logic [31:0]     rem_r  [QuoW+1];
  logic [QuoW-1:0] acc_r  [QuoW+1];
  logic [31:0]     dmag_r [QuoW+1];
  logic            neg_r  [QuoW+1];
  logic            dz_r   [QuoW+1];
  logic            npos_r [QuoW+1];
  logic signed [31:0] quo_r;
  logic [31:0] nmag;
  logic [31:0] dmag;

  assign nmag = num[31] ? 32'(-num) : 32'(num);
  assign dmag = den[31] ? 32'(-den) : 32'(den);

  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    acc_r[0]  <= {nmag, 16'h0000};
    dmag_r[0] <= dmag;
    neg_r[0]  <= num[31] ^ den[31];
    dz_r[0]   <= (den == 32'sd0);
    npos_r[0] <= !num[31];
  end

  for (genvar i = 0; i < QuoW; i++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem_r[i], acc_r[i][QuoW-1]};
    assign ge    = (trial >= {1'b0, dmag_r[i]});
    always_ff @(posedge clk) begin
      rem_r[i+1]  <= ge ? 32'(trial - {1'b0, dmag_r[i]}) : trial[31:0];
      acc_r[i+1]  <= {acc_r[i][QuoW-2:0], ge};
      dmag_r[i+1] <= dmag_r[i];
      neg_r[i+1]  <= neg_r[i];
      dz_r[i+1]   <= dz_r[i];
      npos_r[i+1] <= npos_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (dz_r[QuoW]) begin
      quo_r <= npos_r[QuoW] ? FxMax : FxMin;
    end else if (neg_r[QuoW]) begin
      quo_r <= (acc_r[QuoW] > QuoW'(64'h80000000)) ? FxMin : -$signed(acc_r[QuoW][31:0]);
    end else begin
      quo_r <= (acc_r[QuoW] > QuoW'(64'h7fffffff)) ? FxMax : $signed(acc_r[QuoW][31:0]);
    end
  end

  assign quo = quo_r;
endmodule

// ===== rtl/core/cardiac_cell_derivative_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cardiac_cell_derivative_core
// Modified Nash-Panfilov cell derivatives in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput one item per cycle.
// The latency is set by the two dividers: a prep stage, one quotient bit per stage, an output stage.
// busy is always low and the receiver cannot stall; results appear once each.
// Reset (rst_n, synchronous) clears the valid pipeline; data registers are not reset.
module cardiac_cell_derivative_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  cdd_pkg::cdd_in_t in_item,
  output logic             out_valid,
  output cdd_pkg::cdd_out_t out_item
);
  import cdd_pkg::*;

  // Two stages ahead of the dividers, two behind them.
  localparam int Lat = DivLat + 4;

  logic [Lat-1:0] vld_r;

  // Stage A
  logic signed [31:0] va_r, ra_r, aa_r, sa_r;
  logic signed [31:0] vma_r, vm1_r, vma1_r, mu2v_r, kt_r;
  logic [30:0]        t3_r;
  logic               tneg_r, rz_r, vlo_r;
  logic [31:0]        tmag;
  logic [63:0]        t3p;

  assign tmag = in_item.ta[31] ? 32'(-in_item.ta) : 32'(in_item.ta);
  assign t3p  = 64'(tmag) * 64'(Recip3);

  always_ff @(posedge clk) begin
    va_r   <= in_item.v;
    ra_r   <= in_item.r;
    aa_r   <= in_item.aux;
    sa_r   <= in_item.stim;
    vma_r  <= sat32(64'(in_item.v) - FxA);
    vm1_r  <= sat32(64'(in_item.v) - FxOne);
    vma1_r <= sat32(64'(in_item.v) - FxA - FxOne);
    mu2v_r <= sat32(FxMu2 + 64'(in_item.v));
    kt_r   <= sat32(FxKta * 64'(in_item.v) - 64'(in_item.ta));
    t3_r   <= t3p[63:33];
    tneg_r <= in_item.ta[31];
    rz_r   <= (in_item.aux < FxAuxth) && (in_item.v >= FxVmin);
    vlo_r  <= in_item.v < FxVth;
  end

  // Stage B
  logic signed [31:0] p1_r, pr_r, pmu_r, pg_r, daux_b_r, tden_r, mu2v_b_r;
  logic signed [31:0] vm1_b_r, rb_r, sb_r, kt_b_r;
  logic               rz_b_r, vlo_b_r;
  logic signed [31:0] ta3;

  assign ta3 = tneg_r ? -$signed({1'b0, t3_r}) : $signed({1'b0, t3_r});

  always_ff @(posedge clk) begin
    p1_r     <= fx_mul(va_r, vma_r);
    pr_r     <= fx_mul(ra_r, va_r);
    pmu_r    <= fx_mul(FxMu1, ra_r);
    pg_r     <= fx_mul(va_r, vma1_r);
    daux_b_r <= vlo_r ? sat32(-64'(fx_mul(aa_r, FxDecay))) : FxErr;
    tden_r   <= sat32(64'(ta3) + FxOne);
    mu2v_b_r <= mu2v_r;
    vm1_b_r  <= vm1_r;
    rb_r     <= ra_r;
    sb_r     <= sa_r;
    kt_b_r   <= kt_r;
    rz_b_r   <= rz_r;
    vlo_b_r  <= vlo_r;
  end

  // Dividers
  logic signed [31:0] q_rec, q_rate;

  cdd_div u_div_rec (
    .clk (clk),
    .num (pmu_r),
    .den (mu2v_b_r),
    .quo (q_rec)
  );

  cdd_div u_div_rate (
    .clk (clk),
    .num (FxC006),
    .den (tden_r),
    .quo (q_rate)
  );

  // Stage C and D: finish the potential path while the dividers run.
  logic signed [31:0] cub_r, pr_c_r, s_c_r, g_c_r, kt_c_r, daux_c_r;
  logic               rz_c_r, vlo_c_r;
  cdd_side_t          side_d_r, side_e;

  always_ff @(posedge clk) begin
    cub_r    <= fx_mul(p1_r, vm1_b_r);
    pr_c_r   <= pr_r;
    s_c_r    <= sb_r;
    g_c_r    <= sat32(-64'(rb_r) - 64'(pg_r));
    kt_c_r   <= kt_b_r;
    daux_c_r <= daux_b_r;
    rz_c_r   <= rz_b_r;
    vlo_c_r  <= vlo_b_r;
  end

  always_ff @(posedge clk) begin
    side_d_r.dv   <= sat32(-64'(cub_r) - 64'(pr_c_r) + 64'(s_c_r));
    side_d_r.g    <= g_c_r;
    side_d_r.kt   <= kt_c_r;
    side_d_r.daux <= daux_c_r;
    side_d_r.rz   <= rz_c_r;
    side_d_r.vlo  <= vlo_c_r;
  end

  cdd_delay #(
    .Width ($bits(cdd_side_t)),
    .Depth (QuoW)
  ) u_side_dly (
    .clk  (clk),
    .din  (side_d_r),
    .dout (side_e)
  );

  // Stage E: combine quotients.
  logic signed [31:0] f_r, rate_r, g_e_r, kt_e_r, dv_e_r, daux_e_r;

  always_ff @(posedge clk) begin
    f_r      <= sat32(FxEps + 64'(q_rec));
    rate_r   <= side_e.rz ? 32'sd0 : (side_e.vlo ? q_rate : FxC001);
    g_e_r    <= side_e.g;
    kt_e_r   <= side_e.kt;
    dv_e_r   <= side_e.dv;
    daux_e_r <= side_e.daux;
  end

  // Stage F: final products into the output register.
  cdd_out_t out_r;

  always_ff @(posedge clk) begin
    out_r.dv   <= dv_e_r;
    out_r.dr   <= fx_mul(f_r, g_e_r);
    out_r.dta  <= fx_mul(rate_r, kt_e_r);
    out_r.daux <= daux_e_r;
  end

  logic [Lat-1:0] vld_nxt;
  assign vld_nxt = {vld_r[Lat-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign busy      = 1'b0;
  assign out_valid = vld_r[Lat-1];
  assign out_item  = out_r;
endmodule
